[hdl/frxc_pkg.sv]
// ----------------------------------------------------------------------------
// frxc_pkg
// shared constants, status codes and sequencer states of the frame receiver
// ----------------------------------------------------------------------------
package frxc_pkg;

  localparam int BUF_DEPTH     = 32;
  localparam int NUM_RECEIVERS = 4;
  localparam int MAX_RESULTS   = 32;

  localparam int BUF_AW = $clog2(BUF_DEPTH);
  localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int RES_W  = $clog2(MAX_RESULTS);
  localparam int RX_W   = 2;
  localparam int TOT_W  = 16;
  localparam int CNT_DW = 2 * TOT_W;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int REG_IW = CFG_AW - 2;

  localparam logic [REG_IW-1:0] REG_ROTATE = '0;

  localparam logic [7:0] TOK_START = 8'h2A;
  localparam logic [7:0] TOK_CHECK = 8'h40;
  localparam logic [7:0] TOK_END   = 8'h21;
  localparam logic [7:0] TOK_NL    = 8'h0A;

  localparam logic [CNT_W-1:0] MIN_SPAN = CNT_W'(3);

  typedef enum logic [2:0] {
    ST_PAYLOAD  = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_DISCARD  = 3'd2,
    ST_NO_START = 3'd3,
    ST_SHORT    = 3'd4,
    ST_BAD_POS  = 3'd5,
    ST_BAD_CSUM = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT_RD,
    S_SCAN_RD,
    S_SCAN_USE,
    S_EVAL,
    S_XOR_RD,
    S_XOR_USE,
    S_CHK_RD,
    S_CHK_USE,
    S_UPD,
    S_PL_RD,
    S_PL_USE,
    S_EMIT,
    S_FIN
  } fsm_t;

endpackage

[hdl/frxc_ram.sv]
// ----------------------------------------------------------------------------
// frxc_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module frxc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/frame_receiver_xor_checksum_unit.sv]
// ----------------------------------------------------------------------------
// frame_receiver_xor_checksum_unit
// frame receiver with xor checksum, rotating receivers and pass/fail counts
// ----------------------------------------------------------------------------
// Received bytes are stored in a 32-entry frame buffer ram; a byte that does
// not close a frame is taken without a stall and the next transfer can follow at
// once. A closing byte ('!', newline or a full buffer) starts the frame check,
// during which in_stall stays high. The check walks the buffer through its
// single read port, each access a read step and a use step: a scan of the
// stored bytes (cut short if the first is zero), the xor walk from '*' through
// '@' or to a zero byte, one read of the checksum byte, a count update in the
// counter ram unless the frame is discarded, then the payload transfers, or
// one status result for a failed, discarded or empty frame, which wait while
// the output is stalled. A rotation tick does not stall the input.
// Pass and fail counts live in a second small ram, cleared by per-receiver
// valid bits at reset; the frame buffer needs no clearing since a check only
// reads entries written since the last frame.
// ----------------------------------------------------------------------------
module frame_receiver_xor_checksum_unit
  import frxc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [7:0]        in_rx_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [RX_W-1:0]   out_receiver,
  output logic [7:0]        out_payload_byte,
  output logic              out_last,
  output logic [TOT_W-1:0]  out_pass_total,
  output logic [TOT_W-1:0]  out_fail_total,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // sequencer and frame state
  fsm_t                    state_r, state_nxt;
  logic [RX_W-1:0]         rx_r, rx_nxt, rx_adv;
  logic [CNT_W-1:0]        byte_cnt_r, byte_cnt_nxt;
  logic                    start_seen_r, start_seen_nxt;
  logic                    rotate_r, rotate_nxt;
  logic [BUF_AW-1:0]       a_r, a_nxt;
  logic [BUF_AW-1:0]       start_r, start_nxt;
  logic [BUF_AW-1:0]       at_r, at_nxt;
  logic                    start_fnd_r, start_fnd_nxt;
  logic                    at_fnd_r, at_fnd_nxt;
  logic [7:0]              cs_r, cs_nxt;
  status_t                 status_r, status_nxt;
  logic [RES_W-1:0]        n_r, n_nxt;
  logic [TOT_W-1:0]        pass_tot_r, pass_tot_nxt;
  logic [TOT_W-1:0]        fail_tot_r, fail_tot_nxt;
  logic [NUM_RECEIVERS-1:0] cnt_vld_r, cnt_vld_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [RX_W-1:0]         out_rx_r;
  logic [7:0]              out_byte_r, out_byte_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [TOT_W-1:0]        out_pass_r, out_fail_r;
  logic                    out_ld, out_free;

  // ram ports
  logic                    buf_we, buf_re;
  logic [BUF_AW-1:0]       buf_raddr;
  logic [7:0]              buf_rdata;
  logic                    cnt_we, cnt_re;
  logic [CNT_DW-1:0]       cnt_wdata, cnt_rdata;
  logic [TOT_W-1:0]        pass_cur, fail_cur;

  // config access
  logic                    cfg_wr;
  logic [REG_IW-1:0]       reg_idx;

  logic                    close_byte;
  logic                    pl_last;

  // frame buffer: written at the fill position, read by the check walks
  frxc_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_buf_ram (
    .clk   (clk),
    .we    (buf_we),
    .waddr (byte_cnt_r[BUF_AW-1:0]),
    .wdata (in_rx_byte),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // per-receiver counts, pass in the upper half and fail in the lower half
  frxc_ram #(
    .WIDTH (CNT_DW),
    .DEPTH (NUM_RECEIVERS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (rx_r),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (rx_r),
    .rdata (cnt_rdata)
  );

  // an entry never written since reset reads as zero
  assign pass_cur = cnt_vld_r[rx_r] ? cnt_rdata[CNT_DW-1:TOT_W] : '0;
  assign fail_cur = cnt_vld_r[rx_r] ? cnt_rdata[TOT_W-1:0]      : '0;

  assign rx_adv = (rx_r == RX_W'(NUM_RECEIVERS - 1)) ? '0 : rx_r + RX_W'(1);

  assign close_byte = (in_rx_byte == TOK_NL) || (in_rx_byte == TOK_END);

  // last payload transfer: next index reaches '@' or result limit reached
  assign pl_last = ((a_r + BUF_AW'(1)) == at_r) || (n_r == RES_W'(MAX_RESULTS - 1));

  // output slot may be reloaded when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall = (state_r != S_IDLE);
  assign buf_we   = in_valid && !in_stall && !in_mode;

  // configuration writes land directly, reads are combinational
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (reg_idx == REG_ROTATE) ? CFG_DW'(rotate_r) : '0;

  always_comb begin
    state_nxt      = state_r;
    rx_nxt         = rx_r;
    byte_cnt_nxt   = byte_cnt_r;
    start_seen_nxt = start_seen_r;
    rotate_nxt     = rotate_r;
    a_nxt          = a_r;
    start_nxt      = start_r;
    at_nxt         = at_r;
    start_fnd_nxt  = start_fnd_r;
    at_fnd_nxt     = at_fnd_r;
    cs_nxt         = cs_r;
    status_nxt     = status_r;
    n_nxt          = n_r;
    pass_tot_nxt   = pass_tot_r;
    fail_tot_nxt   = fail_tot_r;
    cnt_vld_nxt    = cnt_vld_r;
    buf_re         = 1'b0;
    buf_raddr      = a_r;
    cnt_re         = 1'b0;
    cnt_we         = 1'b0;
    cnt_wdata      = {pass_tot_nxt, fail_tot_nxt};
    out_ld         = 1'b0;
    out_status_nxt = status_r;
    out_byte_nxt   = '0;
    out_last_nxt   = 1'b1;

    if (cfg_wr && (reg_idx == REG_ROTATE)) begin
      rotate_nxt = pwdata[0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode) begin
            // rotation tick: next receiver, drop the partial frame
            rx_nxt         = rx_adv;
            byte_cnt_nxt   = '0;
            start_seen_nxt = 1'b0;
          end else begin
            start_seen_nxt = start_seen_r || (in_rx_byte == TOK_START);
            byte_cnt_nxt   = start_seen_nxt ? byte_cnt_r + CNT_W'(1) : byte_cnt_r;
            if (close_byte || (byte_cnt_nxt == CNT_W'(BUF_DEPTH))) begin
              state_nxt = S_CNT_RD;
            end
          end
        end
      end
      S_CNT_RD: begin
        cnt_re        = 1'b1;
        a_nxt         = '0;
        start_fnd_nxt = 1'b0;
        at_fnd_nxt    = 1'b0;
        if (byte_cnt_r == '0) begin
          status_nxt = ST_DISCARD;
          state_nxt  = S_UPD;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        buf_re    = 1'b1;
        state_nxt = S_SCAN_USE;
      end
      S_SCAN_USE: begin
        // locate first '*' and first '@'
        if ((a_r == '0) && (buf_rdata == 8'h00)) begin
          status_nxt = ST_DISCARD;
          state_nxt  = S_UPD;
        end else begin
          if (!start_fnd_r && (buf_rdata == TOK_START)) begin
            start_fnd_nxt = 1'b1;
            start_nxt     = a_r;
          end
          if (!at_fnd_r && (buf_rdata == TOK_CHECK)) begin
            at_fnd_nxt = 1'b1;
            at_nxt     = a_r;
          end
          if ((CNT_W'(a_r) + CNT_W'(1)) == byte_cnt_r) begin
            state_nxt = S_EVAL;
          end else begin
            a_nxt     = a_r + BUF_AW'(1);
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_EVAL: begin
        if (!start_fnd_r) begin
          status_nxt = ST_NO_START;
          state_nxt  = S_UPD;
        end else if ((byte_cnt_r - CNT_W'(start_r)) <= MIN_SPAN) begin
          status_nxt = ST_SHORT;
          state_nxt  = S_UPD;
        end else if (!at_fnd_r || (at_r <= start_r) ||
                     ((CNT_W'(at_r) + CNT_W'(1)) >= byte_cnt_r)) begin
          status_nxt = ST_BAD_POS;
          state_nxt  = S_UPD;
        end else begin
          a_nxt     = start_r;
          cs_nxt    = '0;
          state_nxt = S_XOR_RD;
        end
      end
      S_XOR_RD: begin
        buf_re    = 1'b1;
        state_nxt = S_XOR_USE;
      end
      S_XOR_USE: begin
        // checksum walk ends at '@' or at a zero byte
        if (buf_rdata == 8'h00) begin
          state_nxt = S_CHK_RD;
        end else begin
          cs_nxt = cs_r ^ buf_rdata;
          if (a_r == at_r) begin
            state_nxt = S_CHK_RD;
          end else begin
            a_nxt     = a_r + BUF_AW'(1);
            state_nxt = S_XOR_RD;
          end
        end
      end
      S_CHK_RD: begin
        buf_re    = 1'b1;
        buf_raddr = at_r + BUF_AW'(1);
        state_nxt = S_CHK_USE;
      end
      S_CHK_USE: begin
        status_nxt = (cs_r == buf_rdata) ? ST_PAYLOAD : ST_BAD_CSUM;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        // saturating count update, written back to the counter ram unless discarded
        pass_tot_nxt = pass_cur;
        fail_tot_nxt = fail_cur;
        if (status_r == ST_PAYLOAD) begin
          pass_tot_nxt = (pass_cur == '1) ? pass_cur : pass_cur + TOT_W'(1);
        end else if (status_r != ST_DISCARD) begin
          fail_tot_nxt = (fail_cur == '1) ? fail_cur : fail_cur + TOT_W'(1);
        end
        cnt_wdata = {pass_tot_nxt, fail_tot_nxt};
        if (status_r != ST_DISCARD) begin
          cnt_we             = 1'b1;
          cnt_vld_nxt[rx_r]  = 1'b1;
        end
        if (status_r == ST_PAYLOAD) begin
          if ((start_r + BUF_AW'(1)) == at_r) begin
            status_nxt = ST_EMPTY;
            state_nxt  = S_EMIT;
          end else begin
            a_nxt     = start_r + BUF_AW'(1);
            n_nxt     = '0;
            state_nxt = S_PL_RD;
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_PL_RD: begin
        buf_re    = 1'b1;
        state_nxt = S_PL_USE;
      end
      S_PL_USE: begin
        if (out_free) begin
          out_ld         = 1'b1;
          out_status_nxt = ST_PAYLOAD;
          out_byte_nxt   = buf_rdata;
          out_last_nxt   = pl_last;
          if (pl_last) begin
            state_nxt = S_FIN;
          end else begin
            a_nxt     = a_r + BUF_AW'(1);
            n_nxt     = n_r + RES_W'(1);
            state_nxt = S_PL_RD;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_ld    = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // frame done: drop buffer contents, rotate if enabled and not discarded
        byte_cnt_nxt   = '0;
        start_seen_nxt = 1'b0;
        if (rotate_r && (status_r != ST_DISCARD)) begin
          rx_nxt = rx_adv;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_ld ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rx_r         <= '0;
      byte_cnt_r   <= '0;
      start_seen_r <= 1'b0;
      rotate_r     <= 1'b0;
      cnt_vld_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rx_r         <= rx_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      start_seen_r <= start_seen_nxt;
      rotate_r     <= rotate_nxt;
      cnt_vld_r    <= cnt_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // working registers of the check and the output payload
  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    start_r     <= start_nxt;
    at_r        <= at_nxt;
    start_fnd_r <= start_fnd_nxt;
    at_fnd_r    <= at_fnd_nxt;
    cs_r        <= cs_nxt;
    status_r    <= status_nxt;
    n_r         <= n_nxt;
    pass_tot_r  <= pass_tot_nxt;
    fail_tot_r  <= fail_tot_nxt;
    if (out_ld) begin
      out_status_r <= out_status_nxt;
      out_rx_r     <= rx_r;
      out_byte_r   <= out_byte_nxt;
      out_last_r   <= out_last_nxt;
      out_pass_r   <= pass_tot_r;
      out_fail_r   <= fail_tot_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_receiver     = out_rx_r;
  assign out_payload_byte = out_byte_r;
  assign out_last         = out_last_r;
  assign out_pass_total   = out_pass_r;
  assign out_fail_total   = out_fail_r;

endmodule
